// File: sv/hlbct_pkg.sv
// Shared types and constants of the hashed buffer-cache tag engine.
// Depends on nothing; every other file refers to it by scoped names.
package hlbct_pkg;

  localparam int DEFAULT_SLOTS   = 32;
  localparam int DEFAULT_BUCKETS = 13;

  // Sized for the largest configuration (64 slots, 64 buckets).
  localparam int IDX_W = 6;
  localparam int BKT_W = 6;
  localparam int CNT_W = 7;

  localparam logic [1:0] CMD_GET     = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_PIN     = 2'd2;
  localparam logic [1:0] CMD_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_BUF    = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  slot;
    logic [31:0] tick;
  } req_t;

  typedef struct packed {
    logic [4:0] granted_slot;
    logic       hit;
    logic       needs_read;
    logic [1:0] status;
  } rsp_t;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_HIT,
    UPD_CLAIM,
    UPD_PIN,
    UPD_DEC,
    UPD_RELEASE
  } upd_kind_t;

  // Write broadcast from the controller to the cells.
  typedef struct packed {
    upd_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic             relink;
    logic [7:0]       device;
    logic [31:0]      block;
    logic [BKT_W-1:0] bucket;
    logic [31:0]      stamp;
    logic [31:0]      tick;
  } upd_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic             active;
    logic             match_found;
    logic [IDX_W-1:0] match_idx;
    logic             match_valid;
    logic             cand_found;
    logic [IDX_W-1:0] cand_idx;
    logic [BKT_W-1:0] cand_dist;
    logic [31:0]      cand_rt;
    logic [31:0]      cand_stamp;
  } token_t;

endpackage

// File: sv/hashed_lru_block_cache_tags_core.sv
// Top level of the hashed buffer-cache tag engine: controller, remainder
// unit and the chain of slot cells. Depends on hlbct_pkg, hlbct_mod, hlbct_cell.
//
//  channel | signals                      | payload
//  --------+------------------------------+-----------------
//  request | req_valid, req_ready, req    | hlbct_pkg::req_t
//  result  | rsp_valid, rsp_ready, rsp    | hlbct_pkg::rsp_t
//
// A get passes the remainder pipeline, the token crosses the cell chain and
// the chosen update is applied; release, pin and unpin are applied directly.
// A result that is not taken holds the engine in its answer state; the result
// register holds a finished result while the next request is taken. Reset
// clears the slot count, link counter, release times and the chain; no clearing
// pass is needed.
module hashed_lru_block_cache_tags_core #(
  parameter int BUFFER_SLOTS = hlbct_pkg::DEFAULT_SLOTS,
  parameter int BUCKET_COUNT = hlbct_pkg::DEFAULT_BUCKETS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  hlbct_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output hlbct_pkg::rsp_t   rsp
);

  localparam logic [hlbct_pkg::CNT_W-1:0] SLOTS = hlbct_pkg::CNT_W'(BUFFER_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_SCAN,
    S_APPLY,
    S_OP,
    S_RESP
  } state_t;

  state_t                          state;
  hlbct_pkg::req_t                 req_q;
  hlbct_pkg::rsp_t                 res;
  hlbct_pkg::rsp_t                 res_next;
  hlbct_pkg::token_t               fin;
  logic [hlbct_pkg::CNT_W-1:0]     slots_in_use;
  logic [hlbct_pkg::CNT_W-1:0]     slots_in_use_next;
  logic [31:0]                     link_counter;
  logic [31:0]                     link_counter_next;
  hlbct_pkg::upd_t                 upd;
  hlbct_pkg::token_t               chain [BUFFER_SLOTS+1];
  logic [BUFFER_SLOTS-1:0]         zero_vec;
  logic                            mod_done;
  logic [hlbct_pkg::BKT_W-1:0]     home;
  logic                            slot_ok;
  logic                            underflow;

  hlbct_mod #(.BUCKET_COUNT(BUCKET_COUNT)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (req_valid && req_ready && (req.command == hlbct_pkg::CMD_GET)),
    .value (req.block_number),
    .done  (mod_done),
    .rem   (home)
  );

  always_comb begin
    chain[0]        = '0;
    chain[0].active = (state == S_HASH) && mod_done;
  end

  for (genvar g = 0; g < BUFFER_SLOTS; g++) begin : g_cell
    hlbct_cell #(.IDX(g), .BUCKET_COUNT(BUCKET_COUNT)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .n        (slots_in_use),
      .device   (req_q.device),
      .block    (req_q.block_number),
      .home     (home),
      .tok_in   (chain[g]),
      .tok_out  (chain[g+1]),
      .upd      (upd),
      .zero_sel (zero_vec[g])
    );
  end

  assign req_ready = state == S_IDLE;
  assign slot_ok   = hlbct_pkg::CNT_W'(req_q.slot) < slots_in_use;
  assign underflow = !slot_ok || (|zero_vec);

  always_comb begin
    upd               = '0;
    upd.kind          = hlbct_pkg::UPD_NONE;
    upd.idx           = hlbct_pkg::IDX_W'(req_q.slot);
    upd.device        = req_q.device;
    upd.block         = req_q.block_number;
    upd.bucket        = home;
    upd.stamp         = link_counter;
    upd.tick          = req_q.tick;
    res_next          = '0;
    res_next.granted_slot = req_q.slot;
    res_next.status   = hlbct_pkg::ST_OK;
    slots_in_use_next = slots_in_use;
    link_counter_next = link_counter;
    if (state == S_APPLY) begin
      if (fin.match_found) begin
        upd.kind              = hlbct_pkg::UPD_HIT;
        upd.idx               = fin.match_idx;
        res_next.granted_slot = fin.match_idx[4:0];
        res_next.hit          = 1'b1;
        res_next.needs_read   = !fin.match_valid;
      end else if (slots_in_use < SLOTS) begin
        // take the next never-used slot
        upd.kind              = hlbct_pkg::UPD_CLAIM;
        upd.idx               = slots_in_use[hlbct_pkg::IDX_W-1:0];
        upd.relink            = 1'b1;
        res_next.granted_slot = slots_in_use[4:0];
        res_next.needs_read   = 1'b1;
        slots_in_use_next     = slots_in_use + hlbct_pkg::CNT_W'(1);
        link_counter_next     = link_counter + 32'd1;
      end else if (fin.cand_found) begin
        upd.kind              = hlbct_pkg::UPD_CLAIM;
        upd.idx               = fin.cand_idx;
        upd.relink            = fin.cand_dist != '0;
        res_next.granted_slot = fin.cand_idx[4:0];
        res_next.needs_read   = 1'b1;
        if (fin.cand_dist != '0) begin
          link_counter_next = link_counter + 32'd1;
        end
      end else begin
        res_next.granted_slot = '0;
        res_next.status       = hlbct_pkg::ST_NO_BUF;
      end
    end else if (state == S_OP) begin
      if (req_q.command == hlbct_pkg::CMD_PIN) begin
        if (slot_ok) begin
          upd.kind = hlbct_pkg::UPD_PIN;
        end
      end else if (underflow) begin
        res_next.status = hlbct_pkg::ST_UNDERFLOW;
      end else if (req_q.command == hlbct_pkg::CMD_RELEASE) begin
        upd.kind = hlbct_pkg::UPD_RELEASE;
      end else begin
        upd.kind = hlbct_pkg::UPD_DEC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rsp_valid    <= 1'b0;
      slots_in_use <= '0;
      link_counter <= '0;
    end else begin
      slots_in_use <= slots_in_use_next;
      link_counter <= link_counter_next;
      if ((state == S_RESP) && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= (req.command == hlbct_pkg::CMD_GET) ? S_HASH : S_OP;
          end
        end
        S_HASH: begin
          if (mod_done) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chain[BUFFER_SLOTS].active) begin
            state <= S_APPLY;
          end
        end
        S_APPLY, S_OP: begin
          state <= S_RESP;
        end
        S_RESP: begin
          // hold until the result register is free
          if (!rsp_valid || rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
    if (state == S_SCAN) begin
      fin <= chain[BUFFER_SLOTS];
    end
    if ((state == S_APPLY) || (state == S_OP)) begin
      res <= res_next;
    end
    if ((state == S_RESP) && (!rsp_valid || rsp_ready)) begin
      rsp <= res;
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in work");

  a_token_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain[BUFFER_SLOTS].active |-> state == S_SCAN)
    else $error("search token left the chain outside a scan");

  a_slots_bounded: assert property (@(posedge clk) disable iff (rst)
    slots_in_use <= SLOTS)
    else $error("slot count beyond capacity");

  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.hit |-> rsp.status == hlbct_pkg::ST_OK)
    else $error("hit reported with a failing status");

endmodule

// File: sv/hlbct_mod.sv
// Remainder unit: block number mod BUCKET_COUNT in a three-stage pipeline that
// folds the bytes by constant residues, then divides by reciprocal multiply.
// Depends on hlbct_pkg.
module hlbct_mod #(
  parameter int BUCKET_COUNT = hlbct_pkg::DEFAULT_BUCKETS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [31:0]                   value,
  output logic                          done,
  output logic [hlbct_pkg::BKT_W-1:0]   rem
);

  // Residues of 2^0, 2^8, 2^16 and 2^24; the folded sum stays below 2^16.
  localparam logic [15:0] RES0 = 16'(1 % BUCKET_COUNT);
  localparam logic [15:0] RES1 = 16'((1 << 8) % BUCKET_COUNT);
  localparam logic [15:0] RES2 = 16'((1 << 16) % BUCKET_COUNT);
  localparam logic [15:0] RES3 = 16'((1 << 24) % BUCKET_COUNT);
  // ceil(2^23 / BUCKET_COUNT) gives an exact quotient for any 16-bit operand.
  localparam logic [39:0] RECIP   = 40'(((1 << 23) + BUCKET_COUNT - 1) / BUCKET_COUNT);
  localparam logic [15:0] MODULUS = 16'(BUCKET_COUNT);

  logic [2:0]  stage;
  logic [15:0] fold;
  logic [15:0] fold_q;
  logic [15:0] quot;
  logic [39:0] prod;
  logic [15:0] back;
  logic [15:0] diff;

  assign prod = {24'd0, fold} * RECIP;
  assign back = quot * MODULUS;
  assign diff = fold_q - back;
  assign done = stage[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= {stage[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      fold <= (16'(value[7:0]) * RES0) + (16'(value[15:8]) * RES1) +
              (16'(value[23:16]) * RES2) + (16'(value[31:24]) * RES3);
    end
    if (stage[0]) begin
      quot   <= prod[38:23];
      fold_q <= fold;
    end
    // hold the remainder until the next start
    if (stage[1]) begin
      rem <= diff[hlbct_pkg::BKT_W-1:0];
    end
  end

endmodule

// File: sv/hlbct_cell.sv
// One buffer slot: tag, count, valid, release time and link stamp, plus one
// stage of the search chain. Depends on hlbct_pkg.
module hlbct_cell #(
  parameter int IDX          = 0,
  parameter int BUCKET_COUNT = hlbct_pkg::DEFAULT_BUCKETS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [hlbct_pkg::CNT_W-1:0]   n,
  input  logic [7:0]                    device,
  input  logic [31:0]                   block,
  input  logic [hlbct_pkg::BKT_W-1:0]   home,
  input  hlbct_pkg::token_t             tok_in,
  output hlbct_pkg::token_t             tok_out,
  input  hlbct_pkg::upd_t               upd,
  output logic                          zero_sel
);

  localparam logic [hlbct_pkg::IDX_W-1:0] MY_IDX = hlbct_pkg::IDX_W'(IDX);
  localparam logic [hlbct_pkg::CNT_W-1:0] MY_CNT = hlbct_pkg::CNT_W'(IDX);
  localparam logic [hlbct_pkg::BKT_W:0]   MODULUS = (hlbct_pkg::BKT_W+1)'(BUCKET_COUNT);

  logic [7:0]                  ent_device;
  logic [31:0]                 ent_block;
  logic [hlbct_pkg::BKT_W-1:0] ent_bucket;
  logic [7:0]                  refs;
  logic                        valid;
  logic [31:0]                 release_time;
  logic [31:0]                 link_stamp;

  logic                        allocated;
  logic                        sel;
  logic [hlbct_pkg::BKT_W:0]   dsum;
  logic [hlbct_pkg::BKT_W-1:0] bkt_gap;
  logic                        better;
  hlbct_pkg::token_t           tok_next;

  assign allocated = MY_CNT < n;
  assign sel       = upd.idx == MY_IDX;
  assign zero_sel  = sel && (refs == 8'd0);

  // Distance of this entry's bucket from home, walking upward with wrap.
  always_comb begin
    if (ent_bucket >= home) begin
      dsum = {1'b0, ent_bucket} - {1'b0, home};
    end else begin
      dsum = {1'b0, ent_bucket} + MODULUS - {1'b0, home};
    end
    bkt_gap = dsum[hlbct_pkg::BKT_W-1:0];
  end

  always_comb begin
    better = !tok_in.cand_found || (bkt_gap < tok_in.cand_dist) ||
             ((bkt_gap == tok_in.cand_dist) &&
              ((release_time < tok_in.cand_rt) ||
               ((release_time == tok_in.cand_rt) && (link_stamp > tok_in.cand_stamp))));
    tok_next = tok_in;
    if (tok_in.active && allocated) begin
      if (!tok_in.match_found && (ent_device == device) && (ent_block == block)) begin
        tok_next.match_found = 1'b1;
        tok_next.match_idx   = MY_IDX;
        tok_next.match_valid = valid;
      end
      if ((refs == 8'd0) && better) begin
        tok_next.cand_found = 1'b1;
        tok_next.cand_idx   = MY_IDX;
        tok_next.cand_dist  = bkt_gap;
        tok_next.cand_rt    = release_time;
        tok_next.cand_stamp = link_stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      release_time <= '0;
    end else if (sel && (upd.kind == hlbct_pkg::UPD_RELEASE) && (refs == 8'd1)) begin
      release_time <= upd.tick;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      case (upd.kind)
        hlbct_pkg::UPD_HIT: begin
          if (refs != 8'hFF) begin
            refs <= refs + 8'd1;
          end
          valid <= 1'b1;
        end
        hlbct_pkg::UPD_CLAIM: begin
          ent_device <= upd.device;
          ent_block  <= upd.block;
          ent_bucket <= upd.bucket;
          refs       <= 8'd1;
          valid      <= 1'b1;
          if (upd.relink) begin
            link_stamp <= upd.stamp;
          end
        end
        hlbct_pkg::UPD_PIN: begin
          if (refs != 8'hFF) begin
            refs <= refs + 8'd1;
          end
        end
        hlbct_pkg::UPD_DEC, hlbct_pkg::UPD_RELEASE: begin
          refs <= refs - 8'd1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: tb/sv/hashed_lru_block_cache_tags_core_tb.sv
// Self-checking bench for the hashed buffer-cache tag engine: a predictor of the
// tag/refcount/eviction policy checks every result. Depends on hlbct_pkg and the core.
`timescale 1ns / 100ps

module hashed_lru_block_cache_tags_core_tb;

  localparam int NSLOT = 32;
  localparam int NBKT  = 13;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  hlbct_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  hlbct_pkg::rsp_t rsp;

  hashed_lru_block_cache_tags_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("hashed_lru_block_cache_tags_core: mismatch");
    $finish;
  end

  // Predictor state of the cache tags.
  logic [7:0]  tag_dev [NSLOT];
  logic [31:0] tag_blk [NSLOT];
  logic [7:0]  ref_cnt [NSLOT];
  logic        slot_valid [NSLOT];
  logic [31:0] rel_time [NSLOT];
  logic [31:0] link_stamp [NSLOT];
  int unsigned used_slots;
  logic [31:0] link_ctr;

  hlbct_pkg::rsp_t expected_rsps[$];
  int   mismatches;
  int   send_idle_pct, recv_stall_pct;
  int   hold_off_cycles;

  function automatic hlbct_pkg::rsp_t cache_access(hlbct_pkg::req_t r);
    hlbct_pkg::rsp_t o;
    int unsigned home, bkt, best;
    logic done, found;
    o.granted_slot = r.slot;
    o.hit = 1'b0;
    o.needs_read = 1'b0;
    o.status = hlbct_pkg::ST_OK;
    done = 1'b0;
    if (r.command == hlbct_pkg::CMD_GET) begin
      home = r.block_number % NBKT;
      for (int i = 0; i < used_slots && !done; i++) begin
        if (tag_dev[i] == r.device && tag_blk[i] == r.block_number) begin
          if (ref_cnt[i] != 8'hff) ref_cnt[i]++;
          o.needs_read = !slot_valid[i];
          slot_valid[i] = 1'b1;
          o.granted_slot = 5'(i);
          o.hit = 1'b1;
          done = 1'b1;
        end
      end
      if (!done && used_slots < NSLOT) begin
        tag_dev[used_slots] = r.device;
        tag_blk[used_slots] = r.block_number;
        ref_cnt[used_slots] = 8'd1;
        slot_valid[used_slots] = 1'b1;
        link_stamp[used_slots] = link_ctr;
        link_ctr++;
        o.granted_slot = 5'(used_slots);
        o.needs_read = 1'b1;
        used_slots++;
        done = 1'b1;
      end
      for (int k = 0; k < NBKT && !done; k++) begin
        bkt = (home + k) % NBKT;
        found = 1'b0;
        best = 0;
        for (int i = 0; i < used_slots; i++) begin
          if (tag_blk[i] % NBKT != bkt || ref_cnt[i] != 0) continue;
          if (!found || rel_time[i] < rel_time[best] ||
              (rel_time[i] == rel_time[best] && link_stamp[i] > link_stamp[best])) begin
            best = i;
            found = 1'b1;
          end
        end
        if (found) begin
          tag_dev[best] = r.device;
          tag_blk[best] = r.block_number;
          ref_cnt[best] = 8'd1;
          slot_valid[best] = 1'b1;
          if (bkt != home) begin
            link_stamp[best] = link_ctr;
            link_ctr++;
          end
          o.granted_slot = 5'(best);
          o.needs_read = 1'b1;
          done = 1'b1;
        end
      end
      if (!done) begin
        o.status = hlbct_pkg::ST_NO_BUF;
        o.granted_slot = '0;
      end
    end else if (r.command == hlbct_pkg::CMD_PIN) begin
      if (r.slot < used_slots && ref_cnt[r.slot] != 8'hff) ref_cnt[r.slot]++;
    end else begin
      if (r.slot >= used_slots || ref_cnt[r.slot] == 0) begin
        o.status = hlbct_pkg::ST_UNDERFLOW;
      end else begin
        ref_cnt[r.slot]--;
        if (r.command == hlbct_pkg::CMD_RELEASE && ref_cnt[r.slot] == 0)
          rel_time[r.slot] = r.tick;
      end
    end
    return o;
  endfunction

  // Drop valid only while idling, so back-to-back requests keep it high.
  task automatic send_request(hlbct_pkg::req_t r);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    expected_rsps.push_back(cache_access(r));
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      rsp_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      rsp_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    hlbct_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", rsp);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.granted_slot !== want.granted_slot || rsp.hit !== want.hit ||
            rsp.needs_read !== want.needs_read || rsp.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10) $display("result: expected %p, got %p", want, rsp);
        end
      end
    end
  end

  function automatic hlbct_pkg::req_t make_req(logic [1:0] cmd, logic [7:0] dev,
                                               logic [31:0] blk, logic [4:0] slot,
                                               logic [31:0] tick);
    hlbct_pkg::req_t r;
    r.command = cmd;
    r.device = dev;
    r.block_number = blk;
    r.slot = slot;
    r.tick = tick;
    return r;
  endfunction

  // Mostly reuse a small tag pool so hits and evictions happen often.
  function automatic hlbct_pkg::req_t random_req();
    hlbct_pkg::req_t r;
    int unsigned sel;
    r.device = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(2));
    r.block_number = ($urandom_range(4) == 0) ? $urandom : $urandom_range(60);
    r.slot = ($urandom_range(5) == 0) ? 5'($urandom) :
             5'($urandom_range(used_slots == 0 ? 0 : used_slots - 1));
    r.tick = ($urandom_range(9) == 0) ? 32'hffff_ffff : $urandom;
    sel = $urandom_range(99);
    r.command = sel < 40 ? hlbct_pkg::CMD_GET : sel < 80 ? hlbct_pkg::CMD_RELEASE :
                sel < 90 ? hlbct_pkg::CMD_PIN : hlbct_pkg::CMD_UNPIN;
    return r;
  endfunction

  task automatic test_directed();
    send_request(make_req(hlbct_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd0, 32'h0));
    send_request(make_req(hlbct_pkg::CMD_UNPIN, 8'h00, 32'h0, 5'd31, 32'h0));
    send_request(make_req(hlbct_pkg::CMD_PIN, 8'h00, 32'h0, 5'd3, 32'h0));
    send_request(make_req(hlbct_pkg::CMD_GET, 8'hff, 32'hffff_ffff, 5'd31, 32'hffff_ffff));
    send_request(make_req(hlbct_pkg::CMD_GET, 8'hff, 32'hffff_ffff, 5'd0, 32'h0));
    send_request(make_req(hlbct_pkg::CMD_GET, 8'h00, 32'h0, 5'd0, 32'h0));
    send_request(make_req(hlbct_pkg::CMD_GET, 8'h01, 32'h0, 5'd0, 32'h0));
    send_request(make_req(hlbct_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd1, 32'hffff_ffff));
    send_request(make_req(hlbct_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd1, 32'h5));
    send_request(make_req(hlbct_pkg::CMD_UNPIN, 8'h00, 32'h0, 5'd0, 32'h0));
    send_request(make_req(hlbct_pkg::CMD_UNPIN, 8'h00, 32'h0, 5'd0, 32'h0));
    // Drive one slot to saturation with pins.
    for (int i = 0; i < 260; i++)
      send_request(make_req(hlbct_pkg::CMD_PIN, 8'h0, 32'h0, 5'd2, 32'h0));
    send_request(make_req(hlbct_pkg::CMD_GET, 8'h01, 32'h0, 5'd0, 32'h0));
    send_request(make_req(hlbct_pkg::CMD_UNPIN, 8'h00, 32'h0, 5'd2, 32'h0));
  endtask

  // Fill all slots, then exhaust them and exercise the cross-bucket scan.
  task automatic test_fill_and_evict();
    for (int i = 0; i < NSLOT + 2; i++)
      send_request(make_req(hlbct_pkg::CMD_GET, 8'h07, 32'(100 + i), 5'd0, 32'h0));
    send_request(make_req(hlbct_pkg::CMD_GET, 8'h08, 32'd5, 5'd0, 32'h0));
    for (int s = 0; s < NSLOT; s += 3)
      for (int j = 0; j < 4; j++)
        send_request(make_req(hlbct_pkg::CMD_RELEASE, 8'h0, 32'h0, 5'(s), 32'(s % 2)));
    for (int i = 0; i < 12; i++)
      send_request(make_req(hlbct_pkg::CMD_GET, 8'h09, 32'(i * 7), 5'd0, 32'h0));
  endtask

  task automatic test_random(int count, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) send_request(random_req());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 400;
    for (int i = 0; i < 40; i++) send_request(random_req());
  endtask

  initial begin
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    for (int i = 0; i < NSLOT; i++) begin
      ref_cnt[i] = 0;
      rel_time[i] = 0;
      slot_valid[i] = 0;
    end
    used_slots = 0;
    link_ctr = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_fill_and_evict();
    test_random(230, 0, 0);
    test_random(230, 74, 0);
    test_random(230, 0, 74);
    test_random(230, 32, 32);
    test_backpressure();
    req_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        while (expected_rsps.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
      end
      begin
        repeat (200_000) @(posedge clk);
        mismatches++;
      end
    join_any
    disable fork;
    if (mismatches == 0) begin
      $display("hashed_lru_block_cache_tags_core: match");
    end else begin
      $display("hashed_lru_block_cache_tags_core: mismatch");
    end
    $finish;
  end

endmodule
